>>> hdl/ppc_pkg.sv
// shared types for the polygon plane clipper
package ppc_pkg;

	typedef enum logic [1:0] {
		OUT_CROSS = 2'd0,
		OUT_VERT  = 2'd1,
		OUT_MARK  = 2'd2
	} out_kind_t;

	localparam int unsigned CFG_NORMAL_X = 0;
	localparam int unsigned CFG_NORMAL_Y = 1;
	localparam int unsigned CFG_NORMAL_Z = 2;
	localparam int unsigned CFG_OFFSET   = 3;

	localparam logic [31:0] NORMAL_Z_RESET = 32'h0001_0000;

	typedef struct packed {
		logic      load_in;
		logic      mul_go;
		logic      mul_lerp;
		logic [1:0] mul_idx;
		logic      acc_add;
		logic      sat;
		logic      store_first;
		logic      div_init;
		logic      div_step;
		logic      edge_close;
		logic      lerp_add;
		logic [1:0] add_idx;
		logic      out_load;
		out_kind_t out_kind;
		logic      update_prev;
	} ppc_cmd_t;

	typedef struct packed {
		logic cur_in;
		logic prev_in;
		logic first_in;
		logic last;
		logic out_free;
	} ppc_status_t;

endpackage

>>> hdl/ppc_datapath.sv
// datapath: config registers, shared multiplier, distance, divider, interpolation, output
module ppc_datapath #(
	parameter int unsigned MAX_FACE_VERTICES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic [31:0]         vertex_x,
	input  logic [31:0]         vertex_y,
	input  logic [31:0]         vertex_z,
	input  logic                face_last,
	input  ppc_pkg::ppc_cmd_t   cmd,
	output ppc_pkg::ppc_status_t status,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [31:0]         out_x,
	output logic [31:0]         out_y,
	output logic [31:0]         out_z,
	output logic                vertex_valid,
	output logic                is_crossing,
	output logic                face_end,
	output logic [7:0]          out_count
);
	import ppc_pkg::*;

	localparam logic [7:0] COUNT_MAX = 8'(2 * MAX_FACE_VERTICES);

	logic [31:0] norm_q [3];
	logic [31:0] offset_q;
	logic [31:0] cur_q [3];
	logic        last_q;
	logic [31:0] prev_q [3];
	logic [31:0] first_q [3];
	logic signed [47:0] d_q, prev_d_q, first_d_q;
	logic signed [50:0] acc_q;
	logic signed [65:0] prod_s1;
	logic signed [32:0] opa, opb;
	logic signed [47:0] d_sat;
	logic [31:0] p_c [3];
	logic [31:0] q_c [3];
	logic signed [47:0] dp_c, dq_c;
	logic [47:0] mag_p, mag_q;
	logic [49:0] rem_q;
	logic [48:0] den_q;
	logic [16:0] quo_q;
	logic [31:0] res_q [3];
	logic [7:0]  count_q;
	logic        out_valid_q;
	logic [31:0] ox_q, oy_q, oz_q;
	logic        ovv_q, ocr_q, oend_q;
	logic [7:0]  ocnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_q[0] <= '0;
			norm_q[1] <= '0;
			norm_q[2] <= NORMAL_Z_RESET;
			offset_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				2'(CFG_NORMAL_X): norm_q[0] <= cfg_data;
				2'(CFG_NORMAL_Y): norm_q[1] <= cfg_data;
				2'(CFG_NORMAL_Z): norm_q[2] <= cfg_data;
				2'(CFG_OFFSET):   offset_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// edge endpoints: previous to current, or current back to first
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p_c[i] = cmd.edge_close ? cur_q[i] : prev_q[i];
			q_c[i] = cmd.edge_close ? first_q[i] : cur_q[i];
		end
		dp_c = cmd.edge_close ? d_q : prev_d_q;
		dq_c = cmd.edge_close ? first_d_q : d_q;
		mag_p = dp_c[47] ? 48'(-dp_c) : 48'(dp_c);
		mag_q = dq_c[47] ? 48'(-dq_c) : 48'(dq_c);
	end

	always_comb begin
		if (cmd.mul_lerp) begin
			opa = $signed({q_c[cmd.mul_idx][31], q_c[cmd.mul_idx]})
			    - $signed({p_c[cmd.mul_idx][31], p_c[cmd.mul_idx]});
			opb = $signed({16'b0, quo_q});
		end else begin
			opa = $signed({norm_q[cmd.mul_idx][31], norm_q[cmd.mul_idx]});
			opb = $signed({cur_q[cmd.mul_idx][31], cur_q[cmd.mul_idx]});
		end
	end

	always_comb begin
		if (!acc_q[50] && (|acc_q[49:47]))
			d_sat = {1'b0, {47{1'b1}}};
		else if (acc_q[50] && !(&acc_q[49:47]))
			d_sat = {1'b1, 47'b0};
		else
			d_sat = acc_q[47:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cur_q[0] <= vertex_x;
			cur_q[1] <= vertex_y;
			cur_q[2] <= vertex_z;
			last_q   <= face_last;
			acc_q    <= $signed({{19{offset_q[31]}}, offset_q});
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + $signed({prod_s1[65], prod_s1[65:16]});
		end
		if (cmd.mul_go)
			prod_s1 <= opa * opb;
		if (cmd.sat)
			d_q <= d_sat;
		if (cmd.store_first) begin
			first_q[0] <= cur_q[0];
			first_q[1] <= cur_q[1];
			first_q[2] <= cur_q[2];
		end
		if (cmd.update_prev) begin
			prev_q[0] <= cur_q[0];
			prev_q[1] <= cur_q[1];
			prev_q[2] <= cur_q[2];
		end
		// restoring division, one quotient bit per cycle
		if (cmd.div_init) begin
			rem_q <= 50'(mag_p);
			den_q <= 49'(mag_p) + 49'(mag_q);
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_q >= {1'b0, den_q}) begin
				rem_q <= 50'((rem_q - {1'b0, den_q}) << 1);
				quo_q <= {quo_q[15:0], 1'b1};
			end else begin
				rem_q <= 50'(rem_q << 1);
				quo_q <= {quo_q[15:0], 1'b0};
			end
		end
		if (cmd.lerp_add)
			res_q[cmd.add_idx] <= p_c[cmd.add_idx] + prod_s1[47:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_d_q  <= '0;
			first_d_q <= '0;
			count_q   <= '0;
		end else begin
			if (cmd.sat && cmd.store_first)
				first_d_q <= d_sat;
			if (cmd.update_prev)
				prev_d_q <= d_q;
			if (cmd.store_first)
				count_q <= '0;
			else if (cmd.out_load) begin
				if (cmd.out_kind == OUT_MARK)
					count_q <= '0;
				else if (count_q < COUNT_MAX)
					count_q <= count_q + 8'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.out_kind)
				OUT_CROSS: begin
					ox_q <= res_q[0]; oy_q <= res_q[1]; oz_q <= res_q[2];
					ovv_q <= 1'b1; ocr_q <= 1'b1; oend_q <= 1'b0; ocnt_q <= '0;
				end
				OUT_VERT: begin
					ox_q <= cur_q[0]; oy_q <= cur_q[1]; oz_q <= cur_q[2];
					ovv_q <= 1'b1; ocr_q <= 1'b0; oend_q <= 1'b0; ocnt_q <= '0;
				end
				default: begin
					ox_q <= '0; oy_q <= '0; oz_q <= '0;
					ovv_q <= 1'b0; ocr_q <= 1'b0; oend_q <= 1'b1; ocnt_q <= count_q;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign out_x        = ox_q;
	assign out_y        = oy_q;
	assign out_z        = oz_q;
	assign vertex_valid = ovv_q;
	assign is_crossing  = ocr_q;
	assign face_end     = oend_q;
	assign out_count    = ocnt_q;

	assign status.cur_in   = !d_q[47];
	assign status.prev_in  = !prev_d_q[47];
	assign status.first_in = !first_d_q[47];
	assign status.last     = last_q;
	assign status.out_free = !out_valid_q || !out_stall;

endmodule

>>> hdl/ppc_ctrl.sv
// controller state machine sequencing distance, crossing and emit steps
module ppc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ppc_pkg::ppc_status_t status,
	output ppc_pkg::ppc_cmd_t    cmd
);
	import ppc_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_MUL   = 10'b00_0000_0010,
		ST_SAT   = 10'b00_0000_0100,
		ST_CHK1  = 10'b00_0000_1000,
		ST_DIV   = 10'b00_0001_0000,
		ST_LERP  = 10'b00_0010_0000,
		ST_EMITX = 10'b00_0100_0000,
		ST_EMITV = 10'b00_1000_0000,
		ST_CHK2  = 10'b01_0000_0000,
		ST_EMITM = 10'b10_0000_0000
	} state_t;

	localparam logic [4:0] DIV_LAST = 5'd16;
	localparam logic [4:0] MUL_LAST = 5'd3;

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic       closing_q, closing_d;
	logic       start_q, start_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		closing_d = closing_q;
		start_d   = start_q;
		cmd       = '0;
		cmd.out_kind   = OUT_CROSS;
		cmd.edge_close = closing_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					cnt_d   = '0;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_go  = (cnt_q != MUL_LAST);
				cmd.mul_idx = cnt_q[1:0];
				cmd.acc_add = (cnt_q != '0);
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == MUL_LAST)
					state_d = ST_SAT;
			end
			ST_SAT: begin
				cmd.sat         = 1'b1;
				cmd.store_first = start_q;
				state_d = ST_CHK1;
			end
			ST_CHK1: begin
				cmd.edge_close = 1'b0;
				if (!start_q && (status.cur_in != status.prev_in)) begin
					cmd.div_init = 1'b1;
					closing_d = 1'b0;
					cnt_d     = '0;
					state_d   = ST_DIV;
				end else if (status.cur_in)
					state_d = ST_EMITV;
				else
					state_d = ST_CHK2;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == DIV_LAST) begin
					cnt_d   = '0;
					state_d = ST_LERP;
				end
			end
			ST_LERP: begin
				cmd.mul_go   = (cnt_q != MUL_LAST);
				cmd.mul_lerp = 1'b1;
				cmd.mul_idx  = cnt_q[1:0];
				cmd.lerp_add = (cnt_q != '0);
				cmd.add_idx  = cnt_q[1:0] - 2'd1;
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == MUL_LAST)
					state_d = ST_EMITX;
			end
			ST_EMITX: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = OUT_CROSS;
					if (closing_q)
						state_d = ST_EMITM;
					else if (status.cur_in)
						state_d = ST_EMITV;
					else
						state_d = ST_CHK2;
				end
			end
			ST_EMITV: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = OUT_VERT;
					state_d = ST_CHK2;
				end
			end
			ST_CHK2: begin
				// current vertex becomes the previous one, then the closing edge
				cmd.update_prev = 1'b1;
				cmd.edge_close  = 1'b1;
				start_d = 1'b0;
				if (status.last) begin
					if (status.cur_in != status.first_in) begin
						cmd.div_init = 1'b1;
						closing_d = 1'b1;
						cnt_d     = '0;
						state_d   = ST_DIV;
					end else
						state_d = ST_EMITM;
				end else
					state_d = ST_IDLE;
			end
			ST_EMITM: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = OUT_MARK;
					start_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			closing_q <= 1'b0;
			start_q   <= 1'b1;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			closing_q <= closing_d;
			start_q   <= start_d;
		end
	end

endmodule

>>> hdl/polygon_plane_clipper.sv
// Clips polygon faces against the plane n.v + offset = 0, one vertex per input transfer.
// Each vertex computes its distance to the plane, and every edge that crosses it runs a 17-step
// restoring divider for t followed by interpolation on the shared 33x33 multiplier; the last
// vertex of a face also emits the face end marker. Processing of a vertex waits while out_stall
// holds a waiting result in the output register.
// Results leave through a single output register: inside vertices, crossing vertices, and
// on the last vertex of a face a marker carrying the count of emitted vertices. One vertex
// is in flight at a time.
module polygon_plane_clipper #(
	parameter int unsigned MAX_FACE_VERTICES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] vertex_x,
	input  logic [31:0] vertex_y,
	input  logic [31:0] vertex_z,
	input  logic        face_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_x,
	output logic [31:0] out_y,
	output logic [31:0] out_z,
	output logic        vertex_valid,
	output logic        is_crossing,
	output logic        face_end,
	output logic [7:0]  out_count
);
	import ppc_pkg::*;

	ppc_cmd_t    cmd;
	ppc_status_t status;

	ppc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	ppc_datapath #(
		.MAX_FACE_VERTICES (MAX_FACE_VERTICES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.vertex_z     (vertex_z),
		.face_last    (face_last),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_z        (out_z),
		.vertex_valid (vertex_valid),
		.is_crossing  (is_crossing),
		.face_end     (face_end),
		.out_count    (out_count)
	);

endmodule
